// ----- sv/mzht_pkg.sv -----
// shared types and constants for the multi-zone hysteresis thermostat
// no dependencies; imported by mzht_zone_eval and the core
package mzht_pkg;

  localparam int ZONE_COUNT  = 4;
  localparam int RELAY_COUNT = 6;
  localparam int ZONE_IDX_W  = 2;

  localparam logic [5:0] RELAY_LIMIT = 6'((7'd1 << RELAY_COUNT) - 7'd1);

  // sensor plausibility window and auto-mode band, tenths of a degree
  localparam logic signed [11:0] VALID_LOW  = -12'sd500;
  localparam logic signed [11:0] VALID_HIGH = 12'sd1000;
  localparam logic signed [13:0] AUTO_BAND  = 14'sd20;
  localparam logic signed [11:0] TEMP_RESET = 12'sd200;

  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_HEAT   = 3'd1;
  localparam logic [2:0] MODE_COOL   = 3'd2;
  localparam logic [2:0] MODE_AUTO   = 3'd3;
  localparam logic [2:0] MODE_MANUAL = 3'd4;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_EVAL   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] REG_ZONE0     = 3'd0;
  localparam logic [2:0] REG_ZONE1     = 3'd1;
  localparam logic [2:0] REG_ZONE2     = 3'd2;
  localparam logic [2:0] REG_ZONE3     = 3'd3;
  localparam logic [2:0] REG_MIN_ON    = 3'd4;
  localparam logic [2:0] REG_MIN_OFF   = 3'd5;
  localparam logic [2:0] REG_EMERG_HI  = 3'd6;
  localparam logic [2:0] REG_EMERG_LO  = 3'd7;

  typedef struct packed {
    logic signed [7:0] comp;
    logic [5:0]        delta;
    logic [8:0]        setpoint;
    logic              enable;
    logic [2:0]        mode;
    logic [5:0]        mask;
  } zone_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WANT = 4'b0010,
    S_TIME = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

// ----- sv/mzht_zone_eval.sv -----
// hysteresis decision for one zone: desired on/off state from mode and temperature
// depends on mzht_pkg; shared by every zone of an evaluate pass
module mzht_zone_eval import mzht_pkg::*; (
  input  zone_cfg_t          cfg,
  input  logic signed [11:0] temp,
  input  logic               on,
  output logic               want
);

  logic signed [13:0] t;
  logic signed [13:0] sp;
  logic signed [13:0] d;
  logic               heat;
  logic               cool;

  assign t  = 14'(temp) + 14'(cfg.comp);
  assign sp = $signed({5'b0, cfg.setpoint});
  assign d  = $signed({8'b0, cfg.delta});

  assign heat = on ? (t < sp + d) : (t < sp - d);
  assign cool = on ? (t > sp - d) : (t > sp + d);

  always_comb begin
    case (cfg.mode)
      MODE_HEAT:   want = heat;
      MODE_COOL:   want = cool;
      MODE_AUTO: begin
        if (t < sp - AUTO_BAND)      want = heat;
        else if (t > sp + AUTO_BAND) want = cool;
        else                         want = 1'b0;
      end
      MODE_MANUAL: want = on;
      default:     want = 1'b0;
    endcase
  end

endmodule

// ----- sv/multi_zone_hysteresis_thermostat_core.sv -----
// top level of the four-zone on/off thermostat with emergency stop
// depends on mzht_pkg and mzht_zone_eval
//
// input channel: opcode, zone_index, temperature, transfer on in_valid && !in_stall
// output channel: relay_bits, zone_active, emergency_active, sensor_ok, one result
//   per input transfer, transfer on out_valid && !out_stall
// config channel: cfg_index / cfg_data, always ready, write only while idle
// sample, tick and clear-stop (and evaluate while the stop is latched): state updates at
//   the input transfer, and the result is registered from the done state
// evaluate: one shared decision unit visits the zones in order, each zone in a want
//   state (hysteresis decision), then a time state (minimum-time check and relay update),
//   before the result is registered from the done state
// in_stall is high while an item is in flight; a held result does not block the
//   next transfer, but a finished item waits in the done state while an earlier result is held by out_stall
// reset: zone settings and limits return to defaults, temperatures read 20.0,
//   sensors invalid, zones off, relays off, tick count zero, stop cleared
module multi_zone_hysteresis_thermostat_core import mzht_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [1:0]         zone_index,
  input  logic signed [11:0] temperature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         relay_bits,
  output logic [3:0]         zone_active,
  output logic               emergency_active,
  output logic [3:0]         sensor_ok,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  state_t state;

  zone_cfg_t          zone_cfg [ZONE_COUNT];
  logic [3:0][15:0]   min_on;
  logic [3:0][15:0]   min_off;
  logic signed [11:0] emerg_hi;
  logic signed [11:0] emerg_lo;

  logic signed [11:0] zone_temp [ZONE_COUNT];
  logic [3:0]         zone_valid;
  logic [3:0]         zone_on;
  logic [31:0]        zone_last_change [ZONE_COUNT];
  logic [31:0]        tick_count;
  logic               stop_latched;
  logic [5:0]         relay_state;

  logic [ZONE_IDX_W-1:0] zone_cnt;
  logic                  want_r;

  logic        in_xfer;
  logic        cfg_xfer;
  logic        sample_ok;
  logic        want;
  logic        cur_on;
  logic [31:0] elapsed;
  logic [15:0] need;
  logic [5:0]  zmask;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  assign sample_ok = (temperature > VALID_LOW) && (temperature < VALID_HIGH);

  assign cur_on  = zone_on[zone_cnt];
  assign elapsed = tick_count - zone_last_change[zone_cnt];
  assign need    = cur_on ? min_on[zone_cnt] : min_off[zone_cnt];
  assign zmask   = zone_cfg[zone_cnt].mask & RELAY_LIMIT;

  mzht_zone_eval u_eval (
    .cfg  (zone_cfg[zone_cnt]),
    .temp (zone_temp[zone_cnt]),
    .on   (cur_on),
    .want (want)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
        zone_cfg[z] <= '{comp: 8'sd0, delta: 6'd10, setpoint: 9'd220, enable: 1'b0,
                         mode: MODE_OFF, mask: 6'(1 << z)};
      end
      for (int z = 0; z < 4; z++) begin
        min_on[z]  <= 16'd60;
        min_off[z] <= 16'd60;
      end
      emerg_hi <= 12'sd500;
      emerg_lo <= -12'sd100;
    end else if (cfg_xfer) begin
      unique case (cfg_index) inside
        REG_ZONE0, REG_ZONE1, REG_ZONE2, REG_ZONE3: begin
          if (32'(cfg_index) < ZONE_COUNT)
            zone_cfg[cfg_index[ZONE_IDX_W-1:0]] <= zone_cfg_t'(cfg_data[32:0]);
        end
        REG_MIN_ON:   min_on   <= cfg_data;
        REG_MIN_OFF:  min_off  <= cfg_data;
        REG_EMERG_HI: emerg_hi <= $signed(cfg_data[11:0]);
        REG_EMERG_LO: emerg_lo <= $signed(cfg_data[11:0]);
        default: ;
      endcase
    end
  end

  // sequencer and thermostat state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      zone_cnt     <= '0;
      want_r       <= 1'b0;
      zone_valid   <= '0;
      zone_on      <= '0;
      tick_count   <= '0;
      stop_latched <= 1'b0;
      relay_state  <= '0;
      out_valid    <= 1'b0;
      for (int z = 0; z < ZONE_COUNT; z++) begin
        zone_temp[z]        <= TEMP_RESET;
        zone_last_change[z] <= '0;
      end
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall))
        out_valid <= 1'b1;
      else if (out_valid && !out_stall)
        out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= (opcode == OP_EVAL && !stop_latched) ? S_WANT : S_DONE;
            case (opcode)
              OP_SAMPLE: begin
                if (32'(zone_index) < ZONE_COUNT) begin
                  zone_temp[zone_index[ZONE_IDX_W-1:0]]  <= temperature;
                  zone_valid[zone_index[ZONE_IDX_W-1:0]] <= sample_ok;
                  if (sample_ok && (temperature >= emerg_hi || temperature <= emerg_lo)) begin
                    stop_latched <= 1'b1;
                    relay_state  <= '0;
                  end
                end
              end
              OP_EVAL: begin
                if (stop_latched) begin
                  relay_state <= '0;
                end else begin
                  zone_cnt <= '0;
                end
              end
              OP_TICK:  tick_count   <= tick_count + 32'd1;
              default:  stop_latched <= 1'b0;
            endcase
          end
        end
        S_WANT: begin
          // disabled zones and zones without a valid sensor keep their state
          if (zone_cfg[zone_cnt].enable && zone_valid[zone_cnt])
            want_r <= want;
          else
            want_r <= cur_on;
          state <= S_TIME;
        end
        S_TIME: begin
          if (want_r != cur_on && elapsed >= {16'b0, need}) begin
            zone_on[zone_cnt]          <= want_r;
            zone_last_change[zone_cnt] <= tick_count;
            if (want_r) relay_state <= relay_state | zmask;
            else        relay_state <= relay_state & ~zmask;
          end
          if (zone_cnt == ZONE_IDX_W'(ZONE_COUNT - 1)) begin
            state <= S_DONE;
          end else begin
            zone_cnt <= zone_cnt + 1'b1;
            state    <= S_WANT;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload, loaded as the item finishes
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      relay_bits       <= relay_state;
      zone_active      <= zone_on;
      emergency_active <= stop_latched;
      sensor_ok        <= zone_valid;
    end
  end

endmodule
